@@ design/assert_macros.svh @@
// assertion macros for the rtl, included by the sampler top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPL(lbl, clk_i, rstn_i, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
		else $error("same-cycle implication failed");

// antecedent implies consequent in the following cycle
`define ASSERT_NEXT(lbl, clk_i, rstn_i, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");

`endif

@@ design/pis_pkg.sv @@
// types and constants of the poisson inversion sampler
package pis_pkg;

	localparam int unsigned MAX_COUNT_DEF = 100;
	localparam int unsigned DATA_W        = 32;
	localparam int unsigned UNIFORM_W     = 31;
	localparam int unsigned EVENT_COUNT_W = 7;
	localparam int unsigned PADDR_W       = 3;

	localparam logic [DATA_W-1:0] LAMBDA_RESET = 32'd16777216;
	localparam logic [DATA_W-1:0] EXP_RESET    = 32'd1580030169;

	// register index, taken from paddr[2]
	localparam logic REG_LAMBDA = 1'b0;
	localparam logic REG_EXP    = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_MUL_RECIP,
		ST_ACCUM
	} pis_state_t;

	typedef struct packed {
		logic load;
		logic mul_lambda;
		logic mul_recip;
		logic accum;
		logic finish;
	} pis_cmd_t;

	typedef struct packed {
		logic below;
		logic at_cap;
	} pis_status_t;

endpackage

@@ design/pis_ctrl.sv @@
// controller state machine of the poisson inversion sampler
module pis_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  pis_pkg::pis_status_t status,
	output pis_pkg::pis_cmd_t    cmd,
	output logic                 busy,
	output logic                 done
);

	pis_pkg::pis_state_t state_q;
	pis_pkg::pis_state_t state_d;
	logic                done_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pis_pkg::ST_IDLE: begin
				if (start) state_d = pis_pkg::ST_EVAL;
			end
			pis_pkg::ST_EVAL: begin
				if (!status.below || status.at_cap) state_d = pis_pkg::ST_IDLE;
				else state_d = pis_pkg::ST_MUL_RECIP;
			end
			pis_pkg::ST_MUL_RECIP: state_d = pis_pkg::ST_ACCUM;
			pis_pkg::ST_ACCUM:     state_d = pis_pkg::ST_EVAL;
			default:               state_d = pis_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			pis_pkg::ST_IDLE: begin
				cmd.load = start;
			end
			pis_pkg::ST_EVAL: begin
				if (!status.below || status.at_cap) cmd.finish = 1'b1;
				else cmd.mul_lambda = 1'b1;
			end
			pis_pkg::ST_MUL_RECIP: cmd.mul_recip = 1'b1;
			pis_pkg::ST_ACCUM:     cmd.accum = 1'b1;
			default:               cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pis_pkg::ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= cmd.finish;
		end
	end

	assign busy = (state_q != pis_pkg::ST_IDLE);
	assign done = done_q;

endmodule

@@ design/pis_datapath.sv @@
// weight, probability and count datapath with reciprocal table
module pis_datapath #(
	parameter int unsigned MAX_COUNT = pis_pkg::MAX_COUNT_DEF
) (
	input  logic                                 clk,
	input  pis_pkg::pis_cmd_t                    cmd,
	input  logic [pis_pkg::UNIFORM_W-1:0]        uniform_sample,
	input  logic [pis_pkg::DATA_W-1:0]           lambda_q,
	input  logic [pis_pkg::DATA_W-1:0]           exp_neg_lambda,
	output pis_pkg::pis_status_t                 status,
	output logic [pis_pkg::EVENT_COUNT_W-1:0]    event_count,
	output logic                                 cap_reached
);

	localparam int unsigned DW       = pis_pkg::DATA_W;
	localparam int unsigned CNT_W    = $clog2(MAX_COUNT + 1);
	localparam int unsigned ROM_DEPTH = 2 ** CNT_W;

	logic [DW-1:0]                   recip_rom [ROM_DEPTH];

	// entry k holds round(2^32 / k); k = 1 is handled apart since 2^32 needs 33 bits
	for (genvar g = 0; g < ROM_DEPTH; g++) begin : g_recip
		if (g < 2) begin : g_unused
			assign recip_rom[g] = '0;
		end else begin : g_entry
			localparam logic [DW:0] RecipVal = ((33'd1 << DW) + 33'(g >> 1)) / 33'(g);
			assign recip_rom[g] = RecipVal[DW-1:0];
		end
	end

	logic [pis_pkg::UNIFORM_W-1:0]   u_q;
	logic [DW-1:0]                   weight_q;
	logic [DW-1:0]                   prob_q;
	logic [CNT_W-1:0]                count_q;
	logic [2*DW-1:0]                 p1_q;
	logic [DW-1:0]                   recip_q;
	logic [DW-1:0]                   t_q;
	logic [2*DW-1:0]                 p2_q;
	logic [pis_pkg::EVENT_COUNT_W-1:0] event_count_q;
	logic                            cap_q;

	logic [CNT_W-1:0]                k_next;
	logic [DW-1:0]                   t_sat;
	logic [DW-1:0]                   weight_new;
	logic [DW:0]                     prob_sum;

	assign k_next = count_q + CNT_W'(1);

	// (weight * lambda) >> 24, saturated to 32 bits
	assign t_sat = (p1_q[2*DW-1:DW+24] != '0) ? '1 : p1_q[DW+23:24];

	assign weight_new = (count_q == '0) ? t_q : p2_q[2*DW-1:DW];
	assign prob_sum   = {1'b0, prob_q} + {1'b0, weight_new};

	assign status.below  = ({prob_q, 1'b0} < {2'b00, u_q});
	assign status.at_cap = (count_q >= CNT_W'(MAX_COUNT));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			u_q      <= uniform_sample;
			weight_q <= exp_neg_lambda >> 2;
			prob_q   <= exp_neg_lambda >> 2;
			count_q  <= '0;
		end
		if (cmd.mul_lambda) begin
			p1_q    <= {{DW{1'b0}}, weight_q} * {{DW{1'b0}}, lambda_q};
			recip_q <= recip_rom[k_next];
		end
		if (cmd.mul_recip) begin
			t_q  <= t_sat;
			p2_q <= {{DW{1'b0}}, t_sat} * {{DW{1'b0}}, recip_q};
		end
		if (cmd.accum) begin
			weight_q <= weight_new;
			prob_q   <= prob_sum[DW] ? '1 : prob_sum[DW-1:0];
			count_q  <= k_next;
		end
		if (cmd.finish) begin
			event_count_q <= pis_pkg::EVENT_COUNT_W'(count_q);
			cap_q         <= status.below && status.at_cap;
		end
	end

	assign event_count = event_count_q;
	assign cap_reached = cap_q;

endmodule

@@ design/poisson_inversion_sampler_unit.sv @@
// poisson inversion sampler: the search runs from start until eval stops it, then done is registered
// busy drops at the edge where done rises, so the next draw is taken while done is high
// one draw at a time; each search step is a multiply, multiply, add loop through the states
// done is a one-cycle strobe; the receiver cannot stall
// arst_n clears the controller and sets lambda to 1.0 and exp(-lambda) to about exp(-1)
`include "assert_macros.svh"

module poisson_inversion_sampler_unit #(
	parameter int unsigned MAX_COUNT = pis_pkg::MAX_COUNT_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [pis_pkg::UNIFORM_W-1:0]        uniform_sample,
	output logic                                 done,
	output logic [pis_pkg::EVENT_COUNT_W-1:0]    event_count,
	output logic                                 cap_reached,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [pis_pkg::PADDR_W-1:0]          paddr,
	input  logic [pis_pkg::DATA_W-1:0]           pwdata,
	output logic [pis_pkg::DATA_W-1:0]           prdata,
	output logic                                 pready
);

	// count reported when the search stops at the cap, wrapped to the port width
	localparam logic [pis_pkg::EVENT_COUNT_W-1:0] CAP_COUNT =
		pis_pkg::EVENT_COUNT_W'(MAX_COUNT);

	logic [pis_pkg::DATA_W-1:0] lambda_q;
	logic [pis_pkg::DATA_W-1:0] exp_neg_lambda_q;
	logic                       wr_en;
	pis_pkg::pis_cmd_t          cmd;
	pis_pkg::pis_status_t       status;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lambda_q         <= pis_pkg::LAMBDA_RESET;
			exp_neg_lambda_q <= pis_pkg::EXP_RESET;
		end else if (wr_en) begin
			unique case (paddr[2])
				pis_pkg::REG_LAMBDA: lambda_q         <= pwdata;
				pis_pkg::REG_EXP:    exp_neg_lambda_q <= pwdata;
				default:             lambda_q         <= lambda_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			pis_pkg::REG_LAMBDA: prdata = lambda_q;
			pis_pkg::REG_EXP:    prdata = exp_neg_lambda_q;
			default:             prdata = '0;
		endcase
	end

	pis_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	pis_datapath #(
		.MAX_COUNT (MAX_COUNT)
	) u_datapath (
		.clk            (clk),
		.cmd            (cmd),
		.uniform_sample (uniform_sample),
		.lambda_q       (lambda_q),
		.exp_neg_lambda (exp_neg_lambda_q),
		.status         (status),
		.event_count    (event_count),
		.cap_reached    (cap_reached)
	);

	`ASSERT_NEXT(a_start_takes, clk, arst_n, start && !busy, busy)
	`ASSERT_IMPL(a_done_idle, clk, arst_n, done, !busy)
	`ASSERT_NEXT(a_done_pulse, clk, arst_n, done, !done)
	`ASSERT_IMPL(a_cap_count, clk, arst_n, done && cap_reached, event_count == CAP_COUNT)

endmodule

@@ tb/testbench.sv @@
// testbench of the poisson inversion sampler: directed table then random draws vs a predictor
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned MAX_CNT     = pis_pkg::MAX_COUNT_DEF;
	localparam int unsigned STALL_LIMIT = 2000;
	localparam int unsigned TAIL_CYCLES = 3 * MAX_CNT + 20;
	localparam int unsigned RANDOM_DRAWS = 1550;
	localparam logic [63:0] SAT32 = 64'h0000_0000_FFFF_FFFF;

	typedef struct packed {
		logic [pis_pkg::EVENT_COUNT_W-1:0] count;
		logic                              cap;
	} draw_t;

	typedef enum logic [1:0] {
		ROW_DRAW,
		ROW_LAMBDA,
		ROW_EXP
	} row_kind_t;

	typedef struct packed {
		row_kind_t                  kind;
		logic [pis_pkg::DATA_W-1:0] value;
		logic                       typed;
		draw_t                      want;
	} row_t;

	localparam int NUM_ROWS = 27;
	localparam draw_t NONE  = '{count: '0, cap: 1'b0};
	localparam draw_t AT_CAP = '{count: pis_pkg::EVENT_COUNT_W'(MAX_CNT), cap: 1'b1};

	row_t plan [NUM_ROWS] = '{
		'{ROW_DRAW,   32'h0000_0000, 1'b1, NONE},   // reset registers, zero uniform
		'{ROW_DRAW,   32'h7FFF_FFFF, 1'b0, NONE},
		'{ROW_DRAW,   32'h0000_0001, 1'b0, NONE},
		'{ROW_DRAW,   32'h5555_5555, 1'b0, NONE},
		'{ROW_DRAW,   32'h2AAA_AAAA, 1'b0, NONE},
		'{ROW_DRAW,   32'h4000_0000, 1'b0, NONE},
		'{ROW_LAMBDA, 32'h0000_0000, 1'b0, NONE},
		'{ROW_EXP,    32'h0000_0000, 1'b0, NONE},
		'{ROW_DRAW,   32'h7FFF_FFFF, 1'b1, AT_CAP}, // zero start weight runs to the cap
		'{ROW_DRAW,   32'h0000_0001, 1'b1, AT_CAP},
		'{ROW_DRAW,   32'h0000_0000, 1'b1, NONE},
		'{ROW_LAMBDA, 32'hFFFF_FFFF, 1'b0, NONE},
		'{ROW_DRAW,   32'h7FFF_FFFF, 1'b1, AT_CAP}, // registers disagree, still zero weight
		'{ROW_EXP,    32'hFFFF_FFFF, 1'b0, NONE},
		'{ROW_DRAW,   32'h7FFF_FFFF, 1'b0, NONE},   // product and sum saturate
		'{ROW_DRAW,   32'h7FFF_FFFE, 1'b0, NONE},
		'{ROW_DRAW,   32'h0000_0000, 1'b1, NONE},
		'{ROW_LAMBDA, 32'h1400_0000, 1'b0, NONE},
		'{ROW_EXP,    32'd9,         1'b0, NONE},
		'{ROW_DRAW,   32'h7FFF_FFFF, 1'b0, NONE},
		'{ROW_DRAW,   32'h4000_0000, 1'b0, NONE},
		'{ROW_LAMBDA, 32'h0400_0000, 1'b0, NONE},
		'{ROW_EXP,    32'd78664902,  1'b0, NONE},
		'{ROW_DRAW,   32'h7FFF_FFFF, 1'b0, NONE},
		'{ROW_DRAW,   32'h3FFF_FFFF, 1'b0, NONE},
		'{ROW_LAMBDA, pis_pkg::LAMBDA_RESET, 1'b0, NONE},
		'{ROW_EXP,    pis_pkg::EXP_RESET,    1'b0, NONE}
	};

	logic                              clk;
	logic                              arst_n;
	logic                              start;
	logic                              busy;
	logic [pis_pkg::UNIFORM_W-1:0]     uniform_sample;
	logic                              done;
	logic [pis_pkg::EVENT_COUNT_W-1:0] event_count;
	logic                              cap_reached;
	logic                              psel;
	logic                              penable;
	logic                              pwrite;
	logic [pis_pkg::PADDR_W-1:0]       paddr;
	logic [pis_pkg::DATA_W-1:0]        pwdata;
	logic [pis_pkg::DATA_W-1:0]        prdata;
	logic                              pready;

	logic [pis_pkg::DATA_W-1:0] lambda_shadow;
	logic [pis_pkg::DATA_W-1:0] exp_shadow;
	draw_t                      pending_draws [$];
	int unsigned                mismatch_count = 0;
	int unsigned                stall_cycles = 0;

	poisson_inversion_sampler_unit dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.uniform_sample (uniform_sample),
		.done           (done),
		.event_count    (event_count),
		.cap_reached    (cap_reached),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// 1/k in Q0.32 rounded to nearest, 1/1 needs the 33rd bit
	function automatic logic [63:0] recip_q32(input int unsigned k);
		logic [63:0] d;
		d = 64'(k & 32'hFF);
		if (d == 64'd0)
			d = 64'd1;
		return ((64'd1 << 32) + (d >> 1)) / d;
	endfunction

	// inverse transform search in Q2.30, prob compared against the uniform in Q0.31
	function automatic draw_t poisson_count(input logic [pis_pkg::UNIFORM_W-1:0] u,
			input logic [pis_pkg::DATA_W-1:0] lam, input logic [pis_pkg::DATA_W-1:0] e);
		logic [31:0] weight;
		logic [63:0] prob;
		logic [63:0] t;
		int unsigned n;
		bit below;
		draw_t d;
		weight = e >> 2;
		prob = {32'd0, weight};
		n = 0;
		below = (prob << 1) < {33'd0, u};
		while (below && n < MAX_CNT) begin
			t = ({32'd0, weight} * {32'd0, lam}) >> 24;
			if (t > SAT32)
				t = SAT32;
			t = (t * recip_q32(n + 1)) >> 32;
			if (t > SAT32)
				t = SAT32;
			weight = t[31:0];
			n++;
			prob = prob + {32'd0, weight};
			if (prob > SAT32)
				prob = SAT32;
			below = (prob << 1) < {33'd0, u};
		end
		d.count = n[pis_pkg::EVENT_COUNT_W-1:0];
		d.cap = below && (n >= MAX_CNT);
		return d;
	endfunction

	task automatic report_mismatch(input string what, input longint unsigned want,
			input longint unsigned got);
		$display("mismatch on %s: expected %0d, got %0d at %0t", what, want, got, $realtime);
		mismatch_count++;
	endtask

	// registers change only with the sampler idle and every result in
	task automatic write_reg(input logic idx, input logic [pis_pkg::DATA_W-1:0] data);
		start <= 1'b0;
		while (pending_draws.size() != 0)
			@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		if (idx == pis_pkg::REG_LAMBDA)
			lambda_shadow = data;
		else
			exp_shadow = data;
	endtask

	// returns at the edge that takes the draw, start left high
	task automatic send_draw(input logic [pis_pkg::UNIFORM_W-1:0] u);
		start <= 1'b1;
		uniform_sample <= u;
		do
			@(posedge clk);
		while (busy);
	endtask

	task automatic sender_gap(input bit quiet);
		int unsigned r;
		int unsigned gap;
		r = $urandom_range(0, 99);
		if (quiet || r < 50)
			gap = 0;
		else if (r < 85)
			gap = $urandom_range(1, 3);
		else if (r < 97)
			gap = $urandom_range(4, 12);
		else
			gap = $urandom_range(20, 60);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic logic [pis_pkg::UNIFORM_W-1:0] pick_sample();
		int unsigned r;
		r = $urandom_range(0, 9);
		case (r)
			0: return pis_pkg::UNIFORM_W'($urandom_range(0, 15));
			1: return {pis_pkg::UNIFORM_W{1'b1}} - pis_pkg::UNIFORM_W'($urandom_range(0, 4095));
			2: return {pis_pkg::UNIFORM_W{1'b1}} -
				pis_pkg::UNIFORM_W'($urandom_range(0, 1 << 20));
			default: return pis_pkg::UNIFORM_W'($urandom);
		endcase
	endfunction

	// lambda and a matching exp(-lambda) for a few means
	task automatic matched_pair(input int unsigned idx, output logic [pis_pkg::DATA_W-1:0] lam,
			output logic [pis_pkg::DATA_W-1:0] e);
		case (idx)
			0: begin lam = 32'h0019_999A; e = 32'd3886245323; end
			1: begin lam = 32'h0080_0000; e = 32'd2605029509; end
			2: begin lam = 32'h0100_0000; e = 32'd1580030169; end
			3: begin lam = 32'h0200_0000; e = 32'd581260590;  end
			4: begin lam = 32'h0400_0000; e = 32'd78664902;   end
			5: begin lam = 32'h0800_0000; e = 32'd1440776;    end
			6: begin lam = 32'h0C00_0000; e = 32'd26389;      end
			default: begin lam = 32'h1000_0000; e = 32'd483; end
		endcase
	endtask

	task automatic pick_setting();
		int unsigned r;
		logic [pis_pkg::DATA_W-1:0] lam;
		logic [pis_pkg::DATA_W-1:0] e;
		r = $urandom_range(0, 19);
		if (r < 12) begin
			matched_pair($urandom_range(0, 7), lam, e);
		end else if (r < 16) begin
			lam = $urandom_range(0, 32'h1800_0000);
			e = $urandom;
		end else if (r < 18) begin
			lam = $urandom;
			e = $urandom;
		end else begin
			lam = $urandom_range(0, 1) ? '1 : '0;
			e = $urandom_range(0, 1) ? '1 : '0;
		end
		write_reg(pis_pkg::REG_LAMBDA, lam);
		write_reg(pis_pkg::REG_EXP, e);
	endtask

	always @(posedge clk) begin : result_check
		draw_t want;
		if (arst_n && done === 1'b1) begin
			if (pending_draws.size() == 0) begin
				report_mismatch("unexpected result beat", 0, event_count);
			end else begin
				want = pending_draws.pop_front();
				if (event_count !== want.count)
					report_mismatch("event_count", want.count, event_count);
				if (cap_reached !== want.cap)
					report_mismatch("cap_reached", want.cap, cap_reached);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("poisson_inversion_sampler_unit test failed");
			$finish;
		end
	end

	initial begin
		int unsigned drawn;
		int unsigned phase_len;
		bit quiet;
		logic [pis_pkg::UNIFORM_W-1:0] u;
		arst_n = 1'b0;
		start = 1'b0;
		uniform_sample = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		lambda_shadow = pis_pkg::LAMBDA_RESET;
		exp_shadow = pis_pkg::EXP_RESET;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < NUM_ROWS; i++) begin
			case (plan[i].kind)
				ROW_LAMBDA: write_reg(pis_pkg::REG_LAMBDA, plan[i].value);
				ROW_EXP:    write_reg(pis_pkg::REG_EXP, plan[i].value);
				default: begin
					u = plan[i].value[pis_pkg::UNIFORM_W-1:0];
					send_draw(u);
					if (plan[i].typed)
						pending_draws.push_back(plan[i].want);
					else
						pending_draws.push_back(poisson_count(u, lambda_shadow, exp_shadow));
					sender_gap(1'b0);
				end
			endcase
		end

		drawn = 0;
		while (drawn < RANDOM_DRAWS) begin
			pick_setting();
			quiet = ($urandom_range(0, 3) == 0);
			phase_len = $urandom_range(10, 60);
			for (int j = 0; j < phase_len && drawn < RANDOM_DRAWS; j++) begin
				u = pick_sample();
				send_draw(u);
				pending_draws.push_back(poisson_count(u, lambda_shadow, exp_shadow));
				drawn++;
				sender_gap(quiet);
			end
		end

		start <= 1'b0;
		while (pending_draws.size() != 0)
			@(posedge clk);
		// any stray beat would show up within one full search
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("poisson_inversion_sampler_unit test passed");
		else
			$display("poisson_inversion_sampler_unit test failed");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+design
design/pis_pkg.sv
design/pis_ctrl.sv
design/pis_datapath.sv
design/poisson_inversion_sampler_unit.sv
tb/testbench.sv
